// ===== rtl/hav_pkg.sv =====
package hav_pkg;

    localparam int CordicSteps = 24;

    localparam logic [33:0] InvGain = 34'd652032874;
    localparam logic [63:0] RadPerUdeg = 64'd20122276272;   // floor(floor(pi*2^60)/180e6)
    localparam logic [30:0] Q30One = 31'd1073741824;
    localparam logic signed [31:0] FullTurn = 32'sd360000000;
    localparam logic signed [31:0] HalfTurn = 32'sd180000000;

    function automatic logic signed [33:0] atan_step(input int i);
        logic signed [33:0] r;
        case (i)
            0: r = 34'sh03243F6A8;
            1: r = 34'sh01DAC6705;
            2: r = 34'sh00FADBAFC;
            3: r = 34'sh007F56EA6;
            4: r = 34'sh003FEAB76;
            5: r = 34'sh001FFD55B;
            6: r = 34'sh000FFFAAA;
            7: r = 34'sh0007FFF55;
            8: r = 34'sh0003FFFEA;
            9: r = 34'sh0001FFFFD;
            default: begin
                if (i < 30) r = (34'sd1 <<< (30 - i)) - 34'sd1;
                else r = '0;
            end
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cordic;

endpackage

// ===== rtl/hav_cordic.sv =====
module hav_cordic (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic                  i_vec,
    input  hav_pkg::t_cordic      i_d,
    output hav_pkg::t_cordic      o_d
);
    // one micro-rotation per register stage, stages advance on i_en
    hav_pkg::t_cordic r_st [hav_pkg::CordicSteps+1];
    hav_pkg::t_cordic n_st [hav_pkg::CordicSteps+1];

    always_comb begin
        n_st[0] = i_d;
        for (int i = 0; i < hav_pkg::CordicSteps; i++) begin
            logic up;
            up = i_vec ? (r_st[i].y > 0) : (r_st[i].z >= 0);
            if (up != i_vec) begin
                n_st[i+1].x = r_st[i].x - (r_st[i].y >>> i);
                n_st[i+1].y = r_st[i].y + (r_st[i].x >>> i);
            end else begin
                n_st[i+1].x = r_st[i].x + (r_st[i].y >>> i);
                n_st[i+1].y = r_st[i].y - (r_st[i].x >>> i);
            end
            if (up) n_st[i+1].z = r_st[i].z + (i_vec ? hav_pkg::atan_step(i)
                                                    : -hav_pkg::atan_step(i));
            else n_st[i+1].z = r_st[i].z - (i_vec ? hav_pkg::atan_step(i)
                                                  : -hav_pkg::atan_step(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i <= hav_pkg::CordicSteps; i++) r_st[i] <= n_st[i];
        end
    end

    assign o_d = r_st[hav_pkg::CordicSteps];
endmodule

// ===== rtl/haversine_distance_top.sv =====
// pipeline stages: 3 prep, two 25-stage cordic chains, 33-stage root, 8 glue stages
// throughput: one beat per cycle while no output stall is held, each cordic step and each root digit is a stage
// an output stall parks the end beat in an output register; the pipe and the input
// stall from the next cycle until that beat leaves
// reset: synchronous active-low i_rst_n clears valid bits, radius returns to 6371000
module haversine_distance_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lng_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lng_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_distance_cm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int NS = hav_pkg::CordicSteps;
    localparam int SQ = 32;                  // root digits
    localparam int LAT = 3 + (NS + 1) + 5 + (SQ + 1) + (NS + 1) + 3;

    logic [23:0] r_radius;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {8'd0, r_radius} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_radius <= 24'd6371000;
        else if (psel && penable && pwrite && paddr == 2'd0) r_radius <= pwdata[23:0];
    end

    // whole pipe advances unless the output register holds a stalled beat
    logic en;
    logic [LAT-1:0] r_vld;
    logic r_hold_vld;
    assign en = !r_hold_vld;
    assign o_stall = r_hold_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // stage 1: differences, and both latitudes passed through
    logic signed [31:0] r_a1 [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1[0] <= 32'(i_lat_b) - 32'(i_lat_a);
            r_a1[1] <= 32'(i_lng_b) - 32'(i_lng_a);
            r_a1[2] <= 32'(i_lat_a);
            r_a1[3] <= 32'(i_lat_b);
        end
    end

    // stage 2: wrap into [-180e6,180e6), range is within +-2 turns
    function automatic logic signed [31:0] wrap(input logic signed [31:0] v);
        logic signed [31:0] w;
        w = v;
        if (w >= hav_pkg::HalfTurn) w = w - hav_pkg::FullTurn;
        if (w >= hav_pkg::HalfTurn) w = w - hav_pkg::FullTurn;
        if (w < -hav_pkg::HalfTurn) w = w + hav_pkg::FullTurn;
        if (w < -hav_pkg::HalfTurn) w = w + hav_pkg::FullTurn;
        return w;
    endfunction
    logic signed [31:0] r_a2 [4];
    always_ff @(posedge i_clk) begin
        if (en) for (int k = 0; k < 4; k++) r_a2[k] <= wrap(r_a1[k]);
    end

    // stage 3: half angle q30
    logic signed [33:0] r_h [4];
    always_ff @(posedge i_clk) begin
        if (en) for (int k = 0; k < 4; k++) begin
            logic [27:0] mag;
            logic [63:0] p;
            mag = r_a2[k][31] ? 28'(-r_a2[k]) : 28'(r_a2[k]);
            p = (64'(mag) * hav_pkg::RadPerUdeg + 64'h4000_0000) >> 31;
            r_h[k] <= r_a2[k][31] ? -34'(p) : 34'(p);
        end
    end

    hav_pkg::t_cordic cin [4], cout [4];
    for (genvar g = 0; g < 4; g++) begin : g_rot
        assign cin[g] = '{x: hav_pkg::InvGain, y: '0, z: r_h[g]};
        hav_cordic u_rot (.i_clk, .i_en(en), .i_vec(1'b0),
                          .i_d(cin[g]), .o_d(cout[g]));
    end

    // stage a: squares
    logic signed [67:0] r_sq [6];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= cout[0].y * cout[0].y;
            r_sq[1] <= cout[1].y * cout[1].y;
            r_sq[2] <= cout[2].x * cout[2].x;
            r_sq[3] <= cout[2].y * cout[2].y;
            r_sq[4] <= cout[3].x * cout[3].x;
            r_sq[5] <= cout[3].y * cout[3].y;
        end
    end
    // stage b: cosines and terms
    logic signed [33:0] r_ca, r_cb, r_t0, r_t1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ca <= 34'((r_sq[2] - r_sq[3]) >>> 30);
            r_cb <= 34'((r_sq[4] - r_sq[5]) >>> 30);
            r_t0 <= 34'(r_sq[0] >>> 30);
            r_t1 <= 34'(r_sq[1] >>> 30);
        end
    end
    logic signed [33:0] r_cc, r_t0b, r_t1b;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc <= 34'((68'(r_ca) * 68'(r_cb)) >>> 30);
            r_t0b <= r_t0;
            r_t1b <= r_t1;
        end
    end
    logic signed [34:0] r_a;
    always_ff @(posedge i_clk) begin
        if (en) r_a <= 35'(r_t0b) + 35'((68'(r_cc) * 68'(r_t1b)) >>> 30);
    end
    logic [30:0] r_ac;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_a < 0) r_ac <= '0;
            else if (r_a > 35'(hav_pkg::Q30One)) r_ac <= hav_pkg::Q30One;
            else r_ac <= 31'(r_a);
        end
    end

    // integer roots, one digit per stage; radicand < 2^61 so 32 digits
    logic [63:0] r_v [2][SQ+1];
    logic [63:0] r_r [2][SQ+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v[0][0] <= {3'd0, r_ac, 30'd0};
            r_v[1][0] <= {3'd0, 31'(hav_pkg::Q30One - r_ac), 30'd0};
            r_r[0][0] <= '0;
            r_r[1][0] <= '0;
            for (int q = 0; q < 2; q++) for (int i = 0; i < SQ; i++) begin
                logic [63:0] b;
                b = 64'd1 << (62 - 2 * i);
                if (r_v[q][i] >= r_r[q][i] + b) begin
                    r_v[q][i+1] <= r_v[q][i] - (r_r[q][i] + b);
                    r_r[q][i+1] <= (r_r[q][i] >> 1) + b;
                end else begin
                    r_v[q][i+1] <= r_v[q][i];
                    r_r[q][i+1] <= r_r[q][i] >> 1;
                end
            end
        end
    end

    hav_pkg::t_cordic vin, vout;
    assign vin = '{x: 34'(r_r[1][SQ]), y: 34'(r_r[0][SQ]), z: '0};
    hav_cordic u_vec (.i_clk, .i_en(en), .i_vec(1'b1), .i_d(vin), .o_d(vout));

    logic [31:0] r_z2;
    always_ff @(posedge i_clk) begin
        if (en) r_z2 <= vout.z[33] ? 32'd0 : {vout.z[30:0], 1'b0};
    end
    logic [55:0] r_p;
    always_ff @(posedge i_clk) begin
        if (en) r_p <= 56'(r_radius) * 56'(r_z2);
    end
    logic [31:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [63:0] d;
            d = (64'(r_p) * 64'd100 + 64'h2000_0000) >> 30;
            r_out <= (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
        end
    end

    // output register catches a beat stalled at the pipe end
    logic [31:0] r_hold;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hold_vld <= 1'b0;
        else if (r_hold_vld) r_hold_vld <= i_stall;
        else r_hold_vld <= r_vld[LAT-1] && i_stall;
    end
    always_ff @(posedge i_clk) begin
        if (!r_hold_vld) r_hold <= r_out;
    end
    assign o_valid = r_hold_vld || r_vld[LAT-1];
    assign o_distance_cm = r_hold_vld ? r_hold : r_out;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distance_cm)) else $error("lost");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall");
`endif
endmodule
